/* rtl/drcg_pkg.sv */
// Shared constants and types for the distance-ratio color gradient unit.
package drcg_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned MagWidth   = CoordWidth;
  localparam int unsigned SqWidth    = 2 * MagWidth;
  localparam int unsigned D2Width    = SqWidth + 1;
  localparam int unsigned QWidth     = FracBits + 1;
  // Remainder of the square-root recurrence needs two bits above the root.
  localparam int unsigned RemWidth   = D2Width + 2;
  // Running product len2 * q, carried beside the remainder.
  localparam int unsigned LqWidth    = D2Width + QWidth;
  // Index of the root bit resolved by one stage.
  localparam int unsigned BitIdxWidth = $clog2(FracBits);

  localparam logic [QWidth-1:0] QOne = QWidth'(1) << FracBits;

  typedef logic [7:0]  chan_t;
  typedef logic [23:0] rgb_t;

  // Payload that rides along the pipeline.
  typedef struct packed {
    rgb_t c0;
    rgb_t c1;
  } color_pair_t;

  // Blend one channel: floor(((1-q)*c0 + q*c1) / 2^FracBits).
  function automatic chan_t blend(input chan_t c0, input chan_t c1,
                                  input logic [QWidth-1:0] q);
    logic [QWidth+8:0] acc;
    acc = (QWidth+9)'(QOne - q) * (QWidth+9)'(c0) + (QWidth+9)'(q) * (QWidth+9)'(c1);
    return acc[FracBits +: 8];
  endfunction

endpackage

/* rtl/distance_ratio_color_gradient_unit.sv */
// Top level: pipelined distance-ratio color blend, one word per cycle.
// Stages: differences, squared magnitudes, sums and checks, root steps, output register.
// Throughput: one word per cycle; the pipeline advances whenever the
// output register is empty or taken, one root bit resolved per stage.
// Reset clears all valid bits; payload registers are not reset.
module distance_ratio_color_gradient_unit import drcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [23:0] start_color_i,
  input  logic [23:0] end_color_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [23:0] pixel_color_o
);

  localparam int unsigned TW = D2Width + 2 * FracBits;

  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  // Stage 1: differences.
  logic s1_v_q;
  logic signed [DiffWidth-1:0] s1_lx_q, s1_ly_q, s1_dx_q, s1_dy_q;
  color_pair_t s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_lx_q  <= DiffWidth'(end_x_i) - DiffWidth'(start_x_i);
      s1_ly_q  <= DiffWidth'(end_y_i) - DiffWidth'(start_y_i);
      s1_dx_q  <= DiffWidth'(point_x_i) - DiffWidth'(start_x_i);
      s1_dy_q  <= DiffWidth'(point_y_i) - DiffWidth'(start_y_i);
      s1_col_q <= '{c0: start_color_i, c1: end_color_i};
    end
  end

  // Stage 2: magnitudes squared.
  logic s2_v_q;
  logic [2*DiffWidth-1:0] s2_lx2_q, s2_ly2_q, s2_dx2_q, s2_dy2_q;
  color_pair_t s2_col_q;

  function automatic logic [DiffWidth-1:0] absv(input logic signed [DiffWidth-1:0] v);
    return v[DiffWidth-1] ? DiffWidth'(-v) : DiffWidth'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_lx2_q <= absv(s1_lx_q) * absv(s1_lx_q);
      s2_ly2_q <= absv(s1_ly_q) * absv(s1_ly_q);
      s2_dx2_q <= absv(s1_dx_q) * absv(s1_dx_q);
      s2_dy2_q <= absv(s1_dy_q) * absv(s1_dy_q);
      s2_col_q <= s1_col_q;
    end
  end

  // Stage 3: sums, zero-length and saturation checks.
  logic s3_v_q;
  logic [D2Width-1:0] s3_len2_q;
  logic [TW-1:0]      s3_tgt_q;
  logic [QWidth-1:0]  s3_q_q;
  logic               s3_byp_q;
  color_pair_t        s3_col_q;
  logic [D2Width-1:0] len2_s, d2_s;

  always_comb begin
    len2_s = D2Width'(s2_lx2_q) + D2Width'(s2_ly2_q);
    d2_s   = D2Width'(s2_dx2_q) + D2Width'(s2_dy2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_len2_q <= len2_s;
      s3_tgt_q  <= {d2_s, (2*FracBits)'(0)};
      s3_byp_q  <= (len2_s == '0) || (len2_s <= d2_s);
      s3_q_q    <= (len2_s != '0 && len2_s <= d2_s) ? QOne : '0;
      s3_col_q  <= s2_col_q;
    end
  end

  // Root stages, most significant bit first.
  logic               rv   [FracBits+1];
  logic [D2Width-1:0] rl   [FracBits+1];
  logic [TW-1:0]      rt   [FracBits+1];
  logic [LqWidth-1:0] rlq  [FracBits+1];
  logic [QWidth-1:0]  rq   [FracBits+1];
  logic               rb   [FracBits+1];
  color_pair_t        rc   [FracBits+1];

  assign rv[0]  = s3_v_q;
  assign rl[0]  = s3_len2_q;
  assign rt[0]  = s3_tgt_q;
  assign rlq[0] = '0;
  assign rq[0]  = s3_q_q;
  assign rb[0]  = s3_byp_q;
  assign rc[0]  = s3_col_q;

  for (genvar i = 0; i < FracBits; i++) begin : g_root
    drcg_root_step u_step (
      .clk_i, .rst_ni, .en_i(en), .bit_i(BitIdxWidth'(FracBits - 1 - i)),
      .valid_i(rv[i]), .len2_i(rl[i]), .tgt_i(rt[i]), .lq_i(rlq[i]), .q_i(rq[i]),
      .bypass_i(rb[i]), .col_i(rc[i]),
      .valid_o(rv[i+1]), .len2_o(rl[i+1]), .tgt_o(rt[i+1]), .lq_o(rlq[i+1]),
      .q_o(rq[i+1]), .bypass_o(rb[i+1]), .col_o(rc[i+1])
    );
  end

  // Output register: blend channels and repack.
  logic        out_v_q;
  rgb_t        out_q;
  color_pair_t fc;
  logic [QWidth-1:0] fq;

  assign fc = rc[FracBits];
  assign fq = rq[FracBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= rv[FracBits];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {blend(fc.c0[23:16], fc.c1[23:16], fq),
                blend(fc.c0[15:8],  fc.c1[15:8],  fq),
                blend(fc.c0[7:0],   fc.c1[7:0],   fq)};
    end
  end

  assign valid_o       = out_v_q;
  assign pixel_color_o = out_q;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(pixel_color_o))
    else $error("output word changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o)
    else $error("pipeline stalled with empty output");
  a_qmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv[FracBits] |-> fq <= QOne)
    else $error("progress above one");
`endif

endmodule

/* rtl/drcg_root_step.sv */
// One registered step of the restoring division / square-root recurrence.
module drcg_root_step import drcg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [BitIdxWidth-1:0]  bit_i,
  input  logic                    valid_i,
  input  logic [D2Width-1:0]      len2_i,
  input  logic [D2Width+2*FracBits-1:0] tgt_i,
  input  logic [LqWidth-1:0]      lq_i,
  input  logic [QWidth-1:0]       q_i,
  input  logic                    bypass_i,
  input  color_pair_t             col_i,
  output logic                    valid_o,
  output logic [D2Width-1:0]      len2_o,
  output logic [D2Width+2*FracBits-1:0] tgt_o,
  output logic [LqWidth-1:0]      lq_o,
  output logic [QWidth-1:0]       q_o,
  output logic                    bypass_o,
  output color_pair_t             col_o
);

  localparam int unsigned TW = D2Width + 2 * FracBits;
  localparam int unsigned DW = TW + 1;

  logic [QWidth-1:0]  t;
  logic [DW-1:0]      delta;
  logic               take;

  // Try the next bit: len2*(t^2 - q^2) = (len2*q << (bit+1)) + (len2 << 2*bit);
  // keep it when that growth fits in the remaining target.
  always_comb begin
    t     = q_i | (QWidth'(1) << bit_i);
    delta = ((DW'(lq_i) << 1) << bit_i) + (DW'(len2_i) << {bit_i, 1'b0});
    take  = !bypass_i && (delta <= DW'(tgt_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len2_o   <= len2_i;
      tgt_o    <= take ? TW'(DW'(tgt_i) - delta) : tgt_i;
      lq_o     <= take ? lq_i + (LqWidth'(len2_i) << bit_i) : lq_i;
      q_o      <= take ? t : q_i;
      bypass_o <= bypass_i;
      col_o    <= col_i;
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Testbench for the distance-ratio color gradient unit: queued driver, checking monitor.
`timescale 1ns / 100ps
module testbench;
  import drcg_pkg::*;

  typedef struct packed {
    logic signed [15:0] sx, sy, ex, ey, px, py;
    rgb_t c0, c1;
  } seg_word_t;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_i = 1'b0;
  logic ready_o, valid_o;
  logic signed [15:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic signed [15:0] point_x_i = '0, point_y_i = '0;
  logic [23:0] start_color_i = '0, end_color_i = '0;
  logic [23:0] pixel_color_o;

  seg_word_t pending_words[$];
  rgb_t      color_expected[$];
  seg_word_t word_on_bus;
  int unsigned words_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  distance_ratio_color_gradient_unit i_dut (.*);

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Exact progress search and per-channel blend.
  function automatic rgb_t blend_color(seg_word_t w);
    logic signed [16:0] dx, dy;
    logic [127:0] ax, ay, len2, d2, target, tt;
    logic [16:0] q, t;
    rgb_t res;
    int unsigned ch0, ch1;
    dx = 17'(w.ex) - 17'(w.sx);
    dy = 17'(w.ey) - 17'(w.sy);
    ax = dx < 0 ? 128'(-dx) : 128'(dx);
    ay = dy < 0 ? 128'(-dy) : 128'(dy);
    len2 = ax * ax + ay * ay;
    dx = 17'(w.px) - 17'(w.sx);
    dy = 17'(w.py) - 17'(w.sy);
    ax = dx < 0 ? 128'(-dx) : 128'(dx);
    ay = dy < 0 ? 128'(-dy) : 128'(dy);
    d2 = ax * ax + ay * ay;
    q = '0;
    if (len2 == 0) q = '0;
    else if (len2 <= d2) q = 17'h10000;
    else begin
      target = d2 << 32;
      for (int b = 15; b >= 0; b--) begin
        t = q | (17'd1 << b);
        tt = 128'(t) * 128'(t);
        if (len2 * tt <= target) q = t;
      end
    end
    for (int k = 0; k < 3; k++) begin
      ch0 = (w.c0 >> (8 * k)) & 8'hFF;
      ch1 = (w.c1 >> (8 * k)) & 8'hFF;
      res[8*k +: 8] = 8'(((32'h10000 - q) * ch0 + q * ch1) >> 16);
    end
    return res;
  endfunction

  task automatic report_mismatch(input rgb_t got, input rgb_t want);
    $display("mismatch at cycle %0d: pixel_color %06h, want %06h", cycle_count, got, want);
    fail_count++;
  endtask

  function automatic int unsigned send_idle_pct();
    if (words_sent < 160) return 15;
    if (words_sent < 320) return 51;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (words_sent < 160) return 51;
    if (words_sent < 320) return 15;
    return 0;
  endfunction

  // Drive words from the queue; advance on acceptance.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (valid_i && ready_o) begin
        color_expected.push_back(blend_color(word_on_bus));
        words_sent <= words_sent + 1;
      end
      if (!valid_i || ready_o) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          word_on_bus = pending_words.pop_front();
          start_x_i <= word_on_bus.sx;
          start_y_i <= word_on_bus.sy;
          end_x_i <= word_on_bus.ex;
          end_y_i <= word_on_bus.ey;
          point_x_i <= word_on_bus.px;
          point_y_i <= word_on_bus.py;
          start_color_i <= word_on_bus.c0;
          end_color_i <= word_on_bus.c1;
          valid_i <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Check each result word; pace ready, with one long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        if (color_expected.size() == 0) begin
          $display("unexpected word at cycle %0d: %06h", cycle_count, pixel_color_o);
          fail_count++;
        end else begin
          rgb_t want;
          want = color_expected.pop_front();
          if (pixel_color_o !== want) report_mismatch(pixel_color_o, want);
        end
      end
      if (!hold_done && words_sent >= 340) begin
        hold_done <= 1'b1;
        hold_left <= 300;
        ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        ready_i <= 1'b0;
      end else begin
        ready_i <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // Stop on timeout.
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic seg_word_t mk(int sx, int sy, int ex, int ey, int px, int py,
                                   int c0, int c1);
    seg_word_t w;
    w.sx = 16'(sx); w.sy = 16'(sy); w.ex = 16'(ex); w.ey = 16'(ey);
    w.px = 16'(px); w.py = 16'(py); w.c0 = 24'(c0); w.c1 = 24'(c1);
    return w;
  endfunction

  function automatic seg_word_t random_word();
    seg_word_t w;
    int k, n, span;
    w.c0 = 24'($urandom);
    w.c1 = 24'($urandom);
    k = $urandom_range(9);
    if (k < 2) begin
      // Full-range noise.
      {w.sx, w.sy, w.ex, w.ey} = {$urandom, $urandom};
      {w.px, w.py} = $urandom;
    end else begin
      // Pixel on or near the segment, mostly short segments.
      span = (k < 7) ? 64 : 32767;
      w.sx = 16'($urandom_range(65535));
      w.sy = 16'($urandom_range(65535));
      if (k == 9) begin
        w.sx = 16'($signed(w.sx) >>> 2);
        w.sy = 16'($signed(w.sy) >>> 2);
      end
      w.ex = w.sx + 16'($urandom_range(2 * span) - span);
      w.ey = w.sy + 16'($urandom_range(2 * span) - span);
      n = $urandom_range(16);
      w.px = w.sx + 16'((int'(w.ex) - int'(w.sx)) * n / 16) + 16'($urandom_range(2) - 1);
      w.py = w.sy + 16'((int'(w.ey) - int'(w.sy)) * n / 16) + 16'($urandom_range(2) - 1);
      if ($urandom_range(19) == 0) begin w.ex = w.sx; w.ey = w.sy; end
    end
    return w;
  endfunction

  initial begin
    // Directed words: extremes, zero length, saturation, off-segment.
    pending_words.push_back(mk(0, 0, 0, 0, 0, 0, 'h123456, 'hABCDEF));
    pending_words.push_back(mk(5, -7, 5, -7, 100, 100, 'hFFFFFF, 0));
    pending_words.push_back(mk(0, 0, 10, 0, 0, 0, 'hFF0000, 'h00FF00));
    pending_words.push_back(mk(0, 0, 10, 0, 10, 0, 'hFF0000, 'h00FF00));
    pending_words.push_back(mk(0, 0, 10, 0, 5, 0, 'hFFFFFF, 0));
    pending_words.push_back(mk(0, 0, 10, 0, 500, -300, 'h000000, 'hFFFFFF));
    pending_words.push_back(mk(0, 0, 10, 0, 0, 5, 'h808080, 'h7F7F7F));
    pending_words.push_back(mk(-32768, -32768, 32767, 32767, 0, 0, 'hFFFFFF, 0));
    pending_words.push_back(mk(32767, 32767, -32768, -32768, -32768, -32768, 0, 'hFFFFFF));
    pending_words.push_back(mk(-32768, 32767, 32767, -32768, 1, 1, 'h00FF00, 'hFF00FF));
    pending_words.push_back(mk(-32768, -32768, 32767, -32768, 32767, 32767, 'h0F0F0F, 'hF0F0F0));
    pending_words.push_back(mk(-32768, 0, -32767, 0, -32768, 0, 'hFFFFFF, 'hFFFFFF));
    pending_words.push_back(mk(0, 0, 3, 4, 3, 4, 'h010203, 'hFEFDFC));
    pending_words.push_back(mk(0, 0, 3, 4, 1, 1, 'h000000, 'h0000FF));
    pending_words.push_back(mk(0, 0, 1, 1, 0, 1, 'hFF00FF, 'h00FF00));
    pending_words.push_back(mk(100, 100, 101, 100, 100, 100, 'hAAAAAA, 'h555555));
    pending_words.push_back(mk(-1, -1, -1, 1000, -1, 999, 'h000000, 'hFFFFFF));
    pending_words.push_back(mk(32767, 0, -32768, 0, 0, 0, 'hFFFFFF, 0));
    for (int i = 0; i < 450; i++) pending_words.push_back(random_word());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_words.size() == 0 && !valid_i);
    wait (color_expected.size() == 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && color_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/drcg_pkg.sv
rtl/drcg_root_step.sv
rtl/distance_ratio_color_gradient_unit.sv
tb/sv/testbench.sv
